/* hw/rtl/md5_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 package
// Round constants, rotate amounts, initial chaining values and FSM states.
// ----------------------------------------------------------------------------
package md5_pkg;

	localparam logic [31:0] INIT_A = 32'h67452301;
	localparam logic [31:0] INIT_B = 32'hefcdab89;
	localparam logic [31:0] INIT_C = 32'h98badcfe;
	localparam logic [31:0] INIT_D = 32'h10325476;
	localparam logic [7:0]  PAD_BYTE = 8'h80;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_PAD,
		ST_DONE
	} state_t;

	function automatic logic [31:0] round_const(input logic [5:0] k);
		logic [31:0] r;
		case (k)
			6'd0: r = 32'hd76aa478;  6'd1: r = 32'he8c7b756;
			6'd2: r = 32'h242070db;  6'd3: r = 32'hc1bdceee;
			6'd4: r = 32'hf57c0faf;  6'd5: r = 32'h4787c62a;
			6'd6: r = 32'ha8304613;  6'd7: r = 32'hfd469501;
			6'd8: r = 32'h698098d8;  6'd9: r = 32'h8b44f7af;
			6'd10: r = 32'hffff5bb1; 6'd11: r = 32'h895cd7be;
			6'd12: r = 32'h6b901122; 6'd13: r = 32'hfd987193;
			6'd14: r = 32'ha679438e; 6'd15: r = 32'h49b40821;
			6'd16: r = 32'hf61e2562; 6'd17: r = 32'hc040b340;
			6'd18: r = 32'h265e5a51; 6'd19: r = 32'he9b6c7aa;
			6'd20: r = 32'hd62f105d; 6'd21: r = 32'h02441453;
			6'd22: r = 32'hd8a1e681; 6'd23: r = 32'he7d3fbc8;
			6'd24: r = 32'h21e1cde6; 6'd25: r = 32'hc33707d6;
			6'd26: r = 32'hf4d50d87; 6'd27: r = 32'h455a14ed;
			6'd28: r = 32'ha9e3e905; 6'd29: r = 32'hfcefa3f8;
			6'd30: r = 32'h676f02d9; 6'd31: r = 32'h8d2a4c8a;
			6'd32: r = 32'hfffa3942; 6'd33: r = 32'h8771f681;
			6'd34: r = 32'h6d9d6122; 6'd35: r = 32'hfde5380c;
			6'd36: r = 32'ha4beea44; 6'd37: r = 32'h4bdecfa9;
			6'd38: r = 32'hf6bb4b60; 6'd39: r = 32'hbebfbc70;
			6'd40: r = 32'h289b7ec6; 6'd41: r = 32'heaa127fa;
			6'd42: r = 32'hd4ef3085; 6'd43: r = 32'h04881d05;
			6'd44: r = 32'hd9d4d039; 6'd45: r = 32'he6db99e5;
			6'd46: r = 32'h1fa27cf8; 6'd47: r = 32'hc4ac5665;
			6'd48: r = 32'hf4292244; 6'd49: r = 32'h432aff97;
			6'd50: r = 32'hab9423a7; 6'd51: r = 32'hfc93a039;
			6'd52: r = 32'h655b59c3; 6'd53: r = 32'h8f0ccc92;
			6'd54: r = 32'hffeff47d; 6'd55: r = 32'h85845dd1;
			6'd56: r = 32'h6fa87e4f; 6'd57: r = 32'hfe2ce6e0;
			6'd58: r = 32'ha3014314; 6'd59: r = 32'h4e0811a1;
			6'd60: r = 32'hf7537e82; 6'd61: r = 32'hbd3af235;
			6'd62: r = 32'h2ad7d2bb; 6'd63: r = 32'heb86d391;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] rot_amount(input logic [5:0] k);
		logic [4:0] s;
		case ({k[5:4], k[1:0]})
			4'd0: s = 5'd7;   4'd1: s = 5'd12; 4'd2: s = 5'd17; 4'd3: s = 5'd22;
			4'd4: s = 5'd5;   4'd5: s = 5'd9;  4'd6: s = 5'd14; 4'd7: s = 5'd20;
			4'd8: s = 5'd4;   4'd9: s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
			4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
			default: s = 5'd0;
		endcase
		return s;
	endfunction

endpackage

/* hw/rtl/md5_message_digest.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 message digest
// Streams a message in one byte per item and emits the 128-bit digest.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | sink      | in_valid/in_stall  | data_byte, byte_present, end_of_message
//  out     | source    | out_valid/out_stall| digest_first_half, digest_second_half
//
// A byte that does not fill the block is stored and the input stays ready. A byte that completes
// the 64-byte block runs the 64-step round loop on one shared adder/rotate
// unit, one step per cycle, and then folds the working words into the chaining
// words. An end item runs one or two such compressions (two when the tail
// holds 56 bytes or more) and then presents the digest in the output register.
// Reset loads the initial chaining words and clears the bit length and control;
// the block buffer is never read before it is written. in_stall is high while
// a compression runs or while a digest waits for the output side.
// ----------------------------------------------------------------------------
module md5_message_digest (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] digest_first_half,
	output logic [63:0] digest_second_half
);

	md5_pkg::state_t state_q, state_d;

	logic [31:0] blk_q [16];     // block buffer as 16 little-endian words
	logic [31:0] h_q [4];        // chaining words
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [63:0] len_q;
	logic [5:0]  step_q;
	logic        fold_q;         // last cycle of a compression: add into h
	logic        fin_q;          // compression belongs to message end
	logic        pad_q;          // a padding pass follows this compression
	logic [63:0] dig1_q, dig2_q;
	logic        ov_q;

	logic        acc;
	logic [5:0]  fill;
	logic [63:0] len_after;
	logic [3:0]  sel;
	logic [31:0] fn, mw, sum, rot;
	logic [4:0]  sh;

	assign acc       = in_valid && !in_stall;
	assign in_stall  = (state_q != md5_pkg::ST_IDLE) || ov_q;
	assign out_valid = ov_q;
	assign digest_first_half  = dig1_q;
	assign digest_second_half = dig2_q;
	assign fill      = len_q[8:3];
	assign len_after = byte_present ? len_q + 64'd8 : len_q;

	// message word and round function for the current step
	always_comb begin
		case (step_q[5:4])
			2'd0: begin
				fn  = (b_q & c_q) | (~b_q & d_q);
				sel = step_q[3:0];
			end
			2'd1: begin
				fn  = (b_q & d_q) | (c_q & ~d_q);
				sel = 4'(5 * step_q + 1);
			end
			2'd2: begin
				fn  = b_q ^ c_q ^ d_q;
				sel = 4'(3 * step_q + 5);
			end
			default: begin
				fn  = c_q ^ (b_q | ~d_q);
				sel = 4'(7 * step_q);
			end
		endcase
		mw  = blk_q[sel];
		sum = a_q + fn + md5_pkg::round_const(step_q) + mw;
		sh  = md5_pkg::rot_amount(step_q);
		rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= md5_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			md5_pkg::ST_IDLE: begin
				if (acc) begin
					if (byte_present && fill == 6'd63) state_d = md5_pkg::ST_ROUND;
					else if (end_of_message) state_d = md5_pkg::ST_PAD;
				end
			end
			md5_pkg::ST_ROUND: begin
				if (fold_q) begin
					if (pad_q) state_d = md5_pkg::ST_PAD;
					else if (fin_q) state_d = md5_pkg::ST_DONE;
					else state_d = md5_pkg::ST_IDLE;
				end
			end
			md5_pkg::ST_PAD:  state_d = md5_pkg::ST_ROUND;
			md5_pkg::ST_DONE: state_d = md5_pkg::ST_IDLE;
			default:          state_d = md5_pkg::ST_IDLE;
		endcase
	end

	// control and chaining state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q[0] <= md5_pkg::INIT_A;
			h_q[1] <= md5_pkg::INIT_B;
			h_q[2] <= md5_pkg::INIT_C;
			h_q[3] <= md5_pkg::INIT_D;
			len_q  <= '0;
			step_q <= '0;
			fold_q <= 1'b0;
			fin_q  <= 1'b0;
			pad_q  <= 1'b0;
			ov_q   <= 1'b0;
		end else begin
			if (ov_q && !out_stall) ov_q <= 1'b0;
			case (state_q)
				md5_pkg::ST_IDLE: begin
					if (acc) begin
						len_q  <= len_after;
						fin_q  <= end_of_message;
						// end with a full block: the padding block follows it
						pad_q  <= end_of_message && byte_present && fill == 6'd63;
						step_q <= '0;
						fold_q <= 1'b0;
					end
				end
				md5_pkg::ST_PAD: begin
					// tail of 56 or more: compress it, then a length-only block
					pad_q  <= fill >= 6'd56 && !pad_q ? 1'b1 : 1'b0;
					step_q <= '0;
					fold_q <= 1'b0;
				end
				md5_pkg::ST_ROUND: begin
					if (fold_q) begin
						h_q[0] <= h_q[0] + a_q;
						h_q[1] <= h_q[1] + b_q;
						h_q[2] <= h_q[2] + c_q;
						h_q[3] <= h_q[3] + d_q;
						if (pad_q) pad_q <= 1'b1;
					end else begin
						step_q <= step_q + 6'd1;
						if (step_q == 6'd63) fold_q <= 1'b1;
					end
				end
				md5_pkg::ST_DONE: begin
					ov_q   <= 1'b1;
					h_q[0] <= md5_pkg::INIT_A;
					h_q[1] <= md5_pkg::INIT_B;
					h_q[2] <= md5_pkg::INIT_C;
					h_q[3] <= md5_pkg::INIT_D;
					len_q  <= '0;
					fin_q  <= 1'b0;
					pad_q  <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// working registers, block buffer and digest (payload)
	logic two_blk;
	assign two_blk = fill >= 6'd56;
	always_ff @(posedge clk) begin
		case (state_q)
			md5_pkg::ST_IDLE: begin
				if (acc && byte_present) blk_q[fill[5:2]][8*fill[1:0] +: 8] <= data_byte;
				a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
			end
			md5_pkg::ST_PAD: begin
				// first pad pass writes 0x80 and zero fill; length if it fits
				for (int i = 0; i < 64; i++) begin
					if (pad_q && two_blk) begin
						blk_q[4'(i >> 2)][8*(i & 3) +: 8] <=
							(i >= 56) ? len_q[8*(i-56) +: 8] : 8'h00;
					end else if (i == int'(fill)) begin
						blk_q[4'(i >> 2)][8*(i & 3) +: 8] <= md5_pkg::PAD_BYTE;
					end else if (i > int'(fill)) begin
						blk_q[4'(i >> 2)][8*(i & 3) +: 8] <=
							(i >= 56 && !two_blk) ? len_q[8*(i-56) +: 8] : 8'h00;
					end
				end
				a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
			end
			md5_pkg::ST_ROUND: begin
				if (!fold_q) begin
					a_q <= d_q;
					b_q <= b_q + rot;
					c_q <= b_q;
					d_q <= c_q;
				end
			end
			md5_pkg::ST_DONE: begin
				dig1_q <= {h_q[1], h_q[0]};
				dig2_q <= {h_q[3], h_q[2]};
			end
			default: ;
		endcase
	end

endmodule

/* hw/rtl/md5_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 port checker
// Watches the top-level ports for handshake and ordering slips.
// ----------------------------------------------------------------------------
module md5_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        end_of_message,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] digest_first_half,
	input logic [63:0] digest_second_half
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(digest_first_half)
			&& $stable(digest_second_half))
		else $error("digest dropped or changed while stalled");

	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while a digest waits");

	a_plain_byte_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !end_of_message |=> !out_valid)
		else $error("digest without an end item");

	a_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && end_of_message |=> in_stall)
		else $error("end item did not hold the input side");

endmodule

bind md5_message_digest md5_checker u_md5_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.end_of_message(end_of_message),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.digest_first_half(digest_first_half),
	.digest_second_half(digest_second_half)
);
